[hdl/positional_list_insert_erase_core_defines.svh]
// ============================================================================
// Positional list core: assertion macros
// Shared assertion forms used by the checker of the positional list core.
// ============================================================================
`ifndef POSITIONAL_LIST_INSERT_ERASE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_ERASE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/plc_pkg.sv]
// ============================================================================
// Positional list core package
// Field widths, operation and status codes, and the command broadcast to the
// row of storage cells.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    localparam int OP_W   = 2;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 7;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     ins;
        logic                     era;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_plc_cmd;

endpackage

`default_nettype wire

[hdl/positional_list_insert_erase_core.sv]
// The result of an accepted word is in the output register from the next cycle on.
// Throughput: one word per cycle unless stalled; the moving cells all shift in the same cycle.
// A new word is taken whenever the output register is empty or is being taken.
// Reset (synchronous, active low) empties the list and the output register;
// the cell contents are not cleared and are never read before being written.
// ============================================================================
// Positional list insert/erase core
// Ordered list of signed words with read, insert and erase by position,
// stored in a row of shifting cells.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_erase_core #(
    parameter int DEPTH = 64
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [plc_pkg::OP_W-1:0]          i_opcode,
    input  wire logic [plc_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [plc_pkg::DATA_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output logic signed [plc_pkg::DATA_W-1:0]      o_read_value,
    output logic [plc_pkg::ST_W-1:0]               o_status,
    output logic [plc_pkg::CNT_W-1:0]              o_count,
    output logic                                   o_is_empty,
    output logic                                   o_is_full
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W;

    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;
    logic                              r_out_valid;
    logic signed [plc_pkg::DATA_W-1:0] r_read_value;
    logic [plc_pkg::ST_W-1:0]          r_status;

    logic                              w_accept;
    logic [CMPW-1:0]                   w_pos_x;
    logic [CMPW-1:0]                   w_cnt_x;
    logic                              w_full;
    logic                              w_rd_ok;
    logic [plc_pkg::ST_W-1:0]          w_status;
    plc_pkg::t_plc_cmd                 w_cmd;
    logic signed [plc_pkg::DATA_W-1:0] w_rd_data;

    logic signed [plc_pkg::DATA_W-1:0] w_data [DEPTH];
    logic signed [plc_pkg::DATA_W-1:0] w_sel  [DEPTH];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_pos_x = CMPW'(i_position);
    assign w_cnt_x = CMPW'(r_count);
    assign w_full  = (r_count == CW'(DEPTH));

    always_comb begin
        n_count     = r_count;
        w_status    = plc_pkg::ST_OK;
        w_rd_ok     = 1'b0;
        w_cmd.ins   = 1'b0;
        w_cmd.era   = 1'b0;
        w_cmd.pos   = i_position;
        w_cmd.value = i_value;
        unique case (i_opcode)
            plc_pkg::OP_READ: begin
                if (w_pos_x < w_cnt_x) begin
                    w_rd_ok = 1'b1;
                end else begin
                    w_status = plc_pkg::ST_RANGE;
                end
            end
            plc_pkg::OP_INSERT: begin
                // A full list is reported before the position is checked.
                if (w_full) begin
                    w_status = plc_pkg::ST_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    w_status = plc_pkg::ST_RANGE;
                end else begin
                    w_cmd.ins = w_accept;
                    n_count   = r_count + 1'b1;
                end
            end
            plc_pkg::OP_ERASE: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = plc_pkg::ST_RANGE;
                end else begin
                    w_cmd.era = w_accept;
                    n_count   = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Each cell passes its entry to both neighbors; the row ends see themselves.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        plc_cell #(
            .Idx (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_left     ((k == 0) ? w_data[k] : w_data[(k == 0) ? 0 : k - 1]),
            .i_right    ((k == DEPTH - 1) ? w_data[k]
                                          : w_data[(k == DEPTH - 1) ? k : k + 1]),
            .o_data     (w_data[k]),
            .o_sel_data (w_sel[k])
        );
    end

    // Only the addressed cell drives a nonzero word, so an OR selects it.
    always_comb begin
        w_rd_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_data = w_rd_data | w_sel[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= w_rd_ok ? w_rd_data : '0;
            r_status     <= w_status;
        end
    end

    // The count only changes together with the output register, so the
    // flags can come straight from it.
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = plc_pkg::CNT_W'(r_count);
    assign o_is_empty   = (r_count == '0);
    assign o_is_full    = w_full;

endmodule

`default_nettype wire

[hdl/plc_cell.sv]
// ============================================================================
// Positional list storage cell
// Holds one list entry. On an insert it takes the new word or its left
// neighbor's entry; on an erase it takes its right neighbor's entry.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module plc_cell #(
    parameter int Idx = 0
) (
    input  wire                                i_clk,
    input  wire plc_pkg::t_plc_cmd             i_cmd,
    input  wire logic signed [plc_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [plc_pkg::DATA_W-1:0] i_right,
    output logic signed [plc_pkg::DATA_W-1:0]  o_data,
    output logic signed [plc_pkg::DATA_W-1:0]  o_sel_data
);

    logic signed [plc_pkg::DATA_W-1:0] r_data;
    logic                              w_at;
    logic                              w_after;
    logic                              w_at_or_after;

    assign w_at          = (int'(i_cmd.pos) == Idx);
    assign w_after       = (int'(i_cmd.pos) < Idx);
    assign w_at_or_after = w_at | w_after;

    // Entries below the addressed position never move.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (w_at) begin
                r_data <= i_cmd.value;
            end else if (w_after) begin
                r_data <= i_left;
            end
        end else if (i_cmd.era && w_at_or_after) begin
            r_data <= i_right;
        end
    end

    assign o_data     = r_data;
    assign o_sel_data = w_at ? r_data : '0;

endmodule

`default_nettype wire

[hdl/plc_checker.sv]
// ============================================================================
// Positional list core checker
// Port-level checks on the results of the positional list core, attached to
// the top level by a bind statement.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_insert_erase_core_defines.svh"

module plc_checker #(
    parameter int DEPTH = 64
) (
    input wire                                    i_clk,
    input wire                                    i_rst_n,
    input wire                                    o_out_valid,
    input wire                                    i_out_stall,
    input wire logic signed [plc_pkg::DATA_W-1:0] o_read_value,
    input wire logic [plc_pkg::ST_W-1:0]          o_status,
    input wire logic [plc_pkg::CNT_W-1:0]         o_count,
    input wire                                    o_is_empty,
    input wire                                    o_is_full
);

    logic w_ok_cfg;

    // A list that can hold two or more words is never both empty and full.
    assign w_ok_cfg = (DEPTH >= 2);

    `PLC_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, o_out_valid && o_is_empty, o_count == '0, "empty flag with nonzero count")
    `PLC_ASSERT_NOW(a_empty_full, i_clk, i_rst_n, o_out_valid && w_ok_cfg, !(o_is_empty && o_is_full), "list reported empty and full")
    `PLC_ASSERT_NOW(a_read_ok, i_clk, i_rst_n, o_out_valid && (o_read_value != '0), o_status == plc_pkg::ST_OK, "read word on a refused request")
    `PLC_ASSERT_NOW(a_full_status, i_clk, i_rst_n, o_out_valid && (o_status == plc_pkg::ST_FULL), o_is_full, "full status on a list that is not full")
    `PLC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_value) && $stable(o_status), "stalled result changed")

endmodule

bind positional_list_insert_erase_core plc_checker #(
    .DEPTH (DEPTH)
) u_plc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_value (o_read_value),
    .o_status     (o_status),
    .o_count      (o_count),
    .o_is_empty   (o_is_empty),
    .o_is_full    (o_is_full)
);

`default_nettype wire
